### design/gvc_pkg.sv
`default_nettype none

package gvc_pkg;

  localparam int unsigned MAX_WIDTH = 1024;
  localparam int unsigned KSIZE     = 3;
  localparam int unsigned IDX_W     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  localparam int unsigned PIX_W     = 8;
  localparam int unsigned COEF_W    = 8;
  localparam int unsigned KROW_W    = KSIZE * COEF_W;
  localparam int unsigned WIDTH_W   = 11;
  localparam int unsigned HEIGHT_W  = 16;
  localparam int unsigned DIV_SHIFT = 4;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned ADDR_W    = 5;

  // queue depths are powers of two so the pointers wrap on their own
  localparam int unsigned QDEPTH    = 4;
  localparam int unsigned QAW       = $clog2(QDEPTH);
  localparam int unsigned ODEPTH    = 4;
  localparam int unsigned OAW       = $clog2(ODEPTH);

  localparam logic [KROW_W-1:0]   KTOP_RST   = 24'h010201;
  localparam logic [KROW_W-1:0]   KMID_RST   = 24'h020402;
  localparam logic [KROW_W-1:0]   KBOT_RST   = 24'h010201;
  localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 11'd640;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 16'd480;

  typedef enum logic [2:0] {
    REG_KTOP   = 3'd0,
    REG_KMID   = 3'd1,
    REG_KBOT   = 3'd2,
    REG_WIDTH  = 3'd3,
    REG_HEIGHT = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             frame_start;
  } pix_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] filtered;
    logic             frame_end;
  } pix_out_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic [IDX_W-1:0] idx;
    logic             produce;
    logic             last;
  } cmd_t;

  // row 0 is the top row; within a row the left coefficient sits in the high byte
  typedef logic [KSIZE-1:0][KROW_W-1:0] kernel_t;

endpackage

`default_nettype wire

### design/gaussian_3x3_valid_convolution.sv
// 3x3 weighted-window filter over a raster stream of 8-bit pixels, valid region only.
// Input queue side: drive data_i and push; a beat is taken when push is high and full is low.
// Set frame_start on the first pixel of a frame. A W x H frame yields (W-2) x (H-2) results.
// Result queue side: while empty is low, result_o holds the oldest result; pop takes it.
// frame_end marks the last result of a frame.
// Config port: APB, registers at 4*i: kernel top, middle, bottom rows, width, height.
// Write registers only while the block is idle. pready is tied high.
// A pixel passes the pixel queue, line store read stage, window and product registers.
// Throughput: one pixel per cycle unless the result queue is full, set by the one-read one-write
// line store, read on entry to stage 1 and written on exit, with same-address forwarding.
// After reset the line store is swept to zero, one entry a cycle, over all MAX_WIDTH
// (1024) entries; full stays high until the sweep is done.
// When the receiver stops popping, the 4-entry result queue fills, the filter
// pipeline holds, the 4-entry pixel queue fills and full rises; no beat is lost.
`default_nettype none

module gaussian_3x3_valid_convolution import gvc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  pix_in_t           data_i,
  output logic              empty,
  input  logic              pop,
  output pix_out_t          result_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  logic [KROW_W-1:0]   ktop_q, kmid_q, kbot_q;
  logic [WIDTH_W-1:0]  width_q;
  logic [HEIGHT_W-1:0] height_q;
  logic [2:0]          reg_sel;
  logic                cfg_wr;
  kernel_t             kernel;

  logic                accept;
  cmd_t                front_cmd, q_cmd;
  logic                q_full, q_empty, q_pop;
  logic                busy;

  assign pready  = 1'b1;
  assign reg_sel = paddr[ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ktop_q   <= KTOP_RST;
      kmid_q   <= KMID_RST;
      kbot_q   <= KBOT_RST;
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_KTOP:   ktop_q   <= pwdata[KROW_W-1:0];
        REG_KMID:   kmid_q   <= pwdata[KROW_W-1:0];
        REG_KBOT:   kbot_q   <= pwdata[KROW_W-1:0];
        REG_WIDTH:  width_q  <= pwdata[WIDTH_W-1:0];
        REG_HEIGHT: height_q <= pwdata[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_KTOP:   prdata = DATA_W'(ktop_q);
      REG_KMID:   prdata = DATA_W'(kmid_q);
      REG_KBOT:   prdata = DATA_W'(kbot_q);
      REG_WIDTH:  prdata = DATA_W'(width_q);
      REG_HEIGHT: prdata = DATA_W'(height_q);
      default:    prdata = '0;
    endcase
  end

  assign kernel[0] = ktop_q;
  assign kernel[1] = kmid_q;
  assign kernel[2] = kbot_q;

  // hold off input while the line store sweep runs
  assign full   = q_full || busy;
  assign accept = push && !full;

  gvc_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .width_i  (width_q),
    .height_i (height_q),
    .accept_i (accept),
    .data_i   (data_i),
    .cmd_o    (front_cmd)
  );

  gvc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .cmd_i   (front_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .cmd_o   (q_cmd),
    .empty_o (q_empty)
  );

  gvc_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .kernel_i  (kernel),
    .cmd_i     (q_cmd),
    .q_empty_i (q_empty),
    .q_pop_o   (q_pop),
    .busy_o    (busy),
    .result_o  (result_o),
    .empty_o   (empty),
    .pop_i     (pop)
  );

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty)
    else $error("waiting result beat dropped without pop");

  a_width_written: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_wr && (reg_sel == REG_WIDTH) |=> width_q == $past(pwdata[WIDTH_W-1:0]))
    else $error("width register not updated by write");

  a_sweep_done_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> q_empty)
    else $error("pixel queue filled during line store sweep");

endmodule

`default_nettype wire

### design/gvc_front.sv
`default_nettype none

module gvc_front import gvc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [WIDTH_W-1:0]  width_i,
  input  logic [HEIGHT_W-1:0] height_i,
  input  logic                accept_i,
  input  pix_in_t             data_i,
  output cmd_t                cmd_o
);

  logic [IDX_W-1:0]    col_q, col_d;
  logic [HEIGHT_W-1:0] row_q, row_d;
  logic [IDX_W-1:0]    wm1;
  logic [HEIGHT_W-1:0] hm1;
  logic [IDX_W-1:0]    c;
  logic [HEIGHT_W-1:0] r;
  logic                end_col, end_row;

  // clamp the frame size to at least 3x3 and the width to what the line stores can hold
  always_comb begin
    if (width_i < WIDTH_W'(3)) begin
      wm1 = IDX_W'(2);
    end else if (32'(width_i) > MAX_WIDTH) begin
      wm1 = IDX_W'(MAX_WIDTH - 1);
    end else begin
      wm1 = IDX_W'(width_i - WIDTH_W'(1));
    end
    if (height_i < HEIGHT_W'(3)) begin
      hm1 = HEIGHT_W'(2);
    end else begin
      hm1 = height_i - HEIGHT_W'(1);
    end
  end

  always_comb begin
    c       = data_i.frame_start ? '0 : col_q;
    r       = data_i.frame_start ? '0 : row_q;
    end_col = (c >= wm1);
    end_row = (r >= hm1);

    cmd_o.pixel   = data_i.pixel;
    cmd_o.idx     = c;
    cmd_o.produce = (r >= HEIGHT_W'(2)) && (c >= IDX_W'(2));
    cmd_o.last    = end_row && end_col;

    if (end_col) begin
      col_d = '0;
      row_d = end_row ? '0 : r + HEIGHT_W'(1);
    end else begin
      col_d = c + IDX_W'(1);
      row_d = r;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept_i) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

`default_nettype wire

### design/gvc_queue.sv
`default_nettype none

module gvc_queue import gvc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output cmd_t cmd_o,
  output logic empty_o
);

  cmd_t           mem_q [QDEPTH];
  logic [QAW-1:0] wr_q, rd_q;
  logic [QAW:0]   cnt_q, cnt_d;
  logic           do_push, do_pop;

  assign full_o  = (cnt_q == (QAW+1)'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign cmd_o   = mem_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + (QAW+1)'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - (QAW+1)'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + QAW'(1);
      end
      if (do_pop) begin
        rd_q <= rd_q + QAW'(1);
      end
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

### design/gvc_back.sv
`default_nettype none

module gvc_back import gvc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  kernel_t  kernel_i,
  input  cmd_t     cmd_i,
  input  logic     q_empty_i,
  output logic     q_pop_o,
  output logic     busy_o,
  output pix_out_t result_o,
  output logic     empty_o,
  input  logic     pop_i
);

  // line store word: [15:8] row before last, [7:0] last row
  logic [2*PIX_W-1:0] lstore [MAX_WIDTH];
  logic [2*PIX_W-1:0] rdata_q, fwd_q, eff;
  logic               hit_q;

  logic               clearing_q;
  logic [IDX_W-1:0]   clr_q;

  logic               adv;
  logic               s1_valid_q;
  cmd_t               s1_q;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  logic [2*PIX_W-1:0] mem_wdata;

  logic [PIX_W-1:0]   win_q [KSIZE][KSIZE];
  logic               s2_valid_q, s2_last_q;

  logic [PIX_W-1:0]   prod [KSIZE][KSIZE];
  logic [PIX_W-1:0]   prod_q [KSIZE][KSIZE];
  logic               s3_valid_q, s3_last_q;
  logic [PIX_W-1:0]   sum;

  pix_out_t           omem_q [ODEPTH];
  logic [OAW-1:0]     owr_q, ord_q;
  logic [OAW:0]       ocnt_q, ocnt_d;
  logic               o_full, o_push, o_pop;

  assign busy_o  = clearing_q;
  assign o_full  = (ocnt_q == (OAW+1)'(ODEPTH));
  assign adv     = !(s3_valid_q && o_full);
  assign q_pop_o = adv && !clearing_q && !q_empty_i;

  // the item leaving stage 1 writes on the same edge the next one reads: forward it
  assign eff = hit_q ? fwd_q : rdata_q;

  always_comb begin
    mem_we    = clearing_q || (adv && s1_valid_q);
    mem_waddr = clearing_q ? clr_q : s1_q.idx;
    mem_wdata = clearing_q ? '0 : {eff[PIX_W-1:0], s1_q.pixel};
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      lstore[mem_waddr] <= mem_wdata;
    end
    if (q_pop_o) begin
      rdata_q <= lstore[cmd_i.idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_q      <= '0;
    end else if (clearing_q) begin
      clr_q <= clr_q + IDX_W'(1);
      if (clr_q == IDX_W'(MAX_WIDTH - 1)) begin
        clearing_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      hit_q      <= 1'b0;
    end else begin
      if (adv) begin
        s1_valid_q <= q_pop_o;
      end
      if (q_pop_o) begin
        hit_q <= s1_valid_q && (s1_q.idx == cmd_i.idx);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      s1_q  <= cmd_i;
      fwd_q <= {eff[PIX_W-1:0], s1_q.pixel};
    end
  end

  // slide the window one column left and load the new column on the right
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < KSIZE; i++) begin
        for (int j = 0; j < KSIZE; j++) begin
          win_q[i][j] <= '0;
        end
      end
    end else if (adv && s1_valid_q) begin
      for (int i = 0; i < KSIZE; i++) begin
        for (int j = 0; j < KSIZE - 1; j++) begin
          win_q[i][j] <= win_q[i][j+1];
        end
      end
      win_q[0][KSIZE-1] <= eff[2*PIX_W-1:PIX_W];
      win_q[1][KSIZE-1] <= eff[PIX_W-1:0];
      win_q[2][KSIZE-1] <= s1_q.pixel;
    end
  end

  always_comb begin
    logic [PIX_W+COEF_W-1:0] p;
    for (int i = 0; i < KSIZE; i++) begin
      for (int j = 0; j < KSIZE; j++) begin
        p          = win_q[i][j] * kernel_i[i][COEF_W*(KSIZE-1-j) +: COEF_W];
        prod[i][j] = p[DIV_SHIFT +: PIX_W];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      s2_last_q  <= 1'b0;
      s3_valid_q <= 1'b0;
      s3_last_q  <= 1'b0;
    end else if (adv) begin
      s2_valid_q <= s1_valid_q && s1_q.produce;
      s2_last_q  <= s1_q.last;
      s3_valid_q <= s2_valid_q;
      s3_last_q  <= s2_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      prod_q <= prod;
    end
  end

  // only the low byte of the sum is kept, so byte-wide adds suffice
  always_comb begin
    sum = '0;
    for (int i = 0; i < KSIZE; i++) begin
      for (int j = 0; j < KSIZE; j++) begin
        sum = sum + prod_q[i][j];
      end
    end
  end

  assign o_push   = adv && s3_valid_q;
  assign empty_o  = (ocnt_q == '0);
  assign o_pop    = pop_i && !empty_o;
  assign result_o = omem_q[ord_q];

  always_comb begin
    ocnt_d = ocnt_q;
    if (o_push && !o_pop) begin
      ocnt_d = ocnt_q + (OAW+1)'(1);
    end else if (o_pop && !o_push) begin
      ocnt_d = ocnt_q - (OAW+1)'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (o_push) begin
      omem_q[owr_q].filtered  <= sum;
      omem_q[owr_q].frame_end <= s3_last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owr_q  <= '0;
      ord_q  <= '0;
      ocnt_q <= '0;
    end else begin
      if (o_push) begin
        owr_q <= owr_q + OAW'(1);
      end
      if (o_pop) begin
        ord_q <= ord_q + OAW'(1);
      end
      ocnt_q <= ocnt_d;
    end
  end

endmodule

`default_nettype wire

### tb/gaussian_3x3_valid_convolution_tb.sv
`timescale 1ns / 100ps

module gaussian_3x3_valid_convolution_tb;
  import gvc_pkg::*;

  typedef struct packed {
    pix_in_t  item;
    logic     typed;
    pix_out_t want;
  } dir_row_t;

  localparam int DIR_ROWS = 22;
  localparam int RANDOM_PIXELS = 950;

  // 3x3 frames: all white, then all black without frame_start, then restarts mid-frame
  localparam dir_row_t BLUR_ROWS [DIR_ROWS] = '{
    '{'{8'hFF, 1'b1}, 1'b0, '{8'h00, 1'b0}},
    '{'{8'hFF, 1'b0}, 1'b0, '{8'h00, 1'b0}},
    '{'{8'hFF, 1'b0}, 1'b0, '{8'h00, 1'b0}},
    '{'{8'hFF, 1'b0}, 1'b0, '{8'h00, 1'b0}},
    '{'{8'hFF, 1'b0}, 1'b0, '{8'h00, 1'b0}},
    '{'{8'hFF, 1'b0}, 1'b0, '{8'h00, 1'b0}},
    '{'{8'hFF, 1'b0}, 1'b0, '{8'h00, 1'b0}},
    '{'{8'hFF, 1'b0}, 1'b0, '{8'h00, 1'b0}},
    '{'{8'hFF, 1'b0}, 1'b1, '{8'd247, 1'b1}},
    '{'{8'h00, 1'b0}, 1'b0, '{8'h00, 1'b0}},
    '{'{8'h00, 1'b0}, 1'b0, '{8'h00, 1'b0}},
    '{'{8'h00, 1'b0}, 1'b0, '{8'h00, 1'b0}},
    '{'{8'h00, 1'b0}, 1'b0, '{8'h00, 1'b0}},
    '{'{8'h00, 1'b0}, 1'b0, '{8'h00, 1'b0}},
    '{'{8'h00, 1'b0}, 1'b0, '{8'h00, 1'b0}},
    '{'{8'h00, 1'b0}, 1'b0, '{8'h00, 1'b0}},
    '{'{8'h00, 1'b0}, 1'b0, '{8'h00, 1'b0}},
    '{'{8'h00, 1'b0}, 1'b1, '{8'h00, 1'b1}},
    '{'{8'h5A, 1'b1}, 1'b0, '{8'h00, 1'b0}},
    '{'{8'hA5, 1'b0}, 1'b0, '{8'h00, 1'b0}},
    '{'{8'h3C, 1'b1}, 1'b0, '{8'h00, 1'b0}},
    '{'{8'hC3, 1'b0}, 1'b0, '{8'h00, 1'b0}}
  };

  logic              clk_i   = 1'b0;
  logic              rst_ni  = 1'b0;
  logic              push    = 1'b0;
  pix_in_t           data_i  = '0;
  logic              pop     = 1'b0;
  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [ADDR_W-1:0] paddr   = '0;
  logic [DATA_W-1:0] pwdata  = '0;
  logic              full;
  logic              empty;
  pix_out_t          result_o;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  gaussian_3x3_valid_convolution u_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push     (push),
    .full     (full),
    .data_i   (data_i),
    .empty    (empty),
    .pop      (pop),
    .result_o (result_o),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // filter model state
  logic [PIX_W-1:0]    prev_row  [MAX_WIDTH];
  logic [PIX_W-1:0]    older_row [MAX_WIDTH];
  logic [PIX_W-1:0]    win       [9];
  logic [KROW_W-1:0]   kern      [3];
  logic [WIDTH_W-1:0]  width_reg;
  logic [HEIGHT_W-1:0] height_reg;
  int unsigned         col_cnt;
  int unsigned         row_cnt;

  pix_out_t expected_pixels [$];
  pix_out_t oldest;
  int       pixels_sent     = 0;
  int       results_checked = 0;
  int       settings_run    = 0;
  int       mismatches      = 0;
  int       send_idle_pct   = 0;
  int       recv_idle_pct   = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    #1000000;
    $display("TB_ERROR");
    $finish;
  end

  task automatic note_mismatch(input string what, input int want, input int got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch on %s at %0t: expected %0d, got %0d", what, $time, want, got);
  endtask

  function automatic bit blur_pixel(input pix_in_t item, output pix_out_t res);
    int unsigned w, h, c, r, idx;
    logic [31:0] acc;
    bit          last;
    w = width_reg;
    if (w < 3) w = 3;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    h = height_reg;
    if (h < 3) h = 3;
    if (item.frame_start) begin
      col_cnt = 0;
      row_cnt = 0;
    end
    c = col_cnt;
    r = row_cnt;
    idx = c % MAX_WIDTH;
    for (int i = 0; i < 3; i++) begin
      win[3*i]   = win[3*i+1];
      win[3*i+1] = win[3*i+2];
    end
    win[2] = older_row[idx];
    win[5] = prev_row[idx];
    win[8] = item.pixel;
    older_row[idx] = prev_row[idx];
    prev_row[idx]  = item.pixel;
    last = (r >= h - 1) && (c >= w - 1);
    // a counter past a shrunken size wraps as if it stood on the last position
    if (c >= w - 1) begin
      col_cnt = 0;
      row_cnt = (r >= h - 1) ? 0 : r + 1;
    end else begin
      col_cnt = c + 1;
    end
    res = '0;
    if (r < 2 || c < 2) return 1'b0;
    acc = '0;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        acc += (32'(win[3*i+j]) * 32'(kern[i][8*(2-j) +: 8])) >> DIV_SHIFT;
    res.filtered  = acc[PIX_W-1:0];
    res.frame_end = last;
    return 1'b1;
  endfunction

  // beat checker: sample on the rising edge, before the block updates
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (expected_pixels.size() == 0) begin
        note_mismatch("unexpected result beat", -1, result_o.filtered);
      end else begin
        oldest = expected_pixels.pop_front();
        results_checked++;
        if (result_o.filtered !== oldest.filtered)
          note_mismatch("filtered", oldest.filtered, result_o.filtered);
        if (result_o.frame_end !== oldest.frame_end)
          note_mismatch("frame_end", oldest.frame_end, result_o.frame_end);
      end
    end
  end

  always @(negedge clk_i)
    pop <= ($urandom_range(0, 99) >= recv_idle_pct);

  // entered and left on a falling edge; push stays high for a following beat
  task automatic send_pixel(input pix_in_t item, input bit typed, input pix_out_t want);
    pix_out_t res;
    bit       produced;
    if (pixels_sent < 340) begin
      send_idle_pct = 35;
      recv_idle_pct = 86;
    end else if (pixels_sent < 680) begin
      send_idle_pct = 86;
      recv_idle_pct = 35;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push   <= 1'b1;
    data_i <= item;
    do @(posedge clk_i); while (full);
    produced = blur_pixel(item, res);
    if (typed) expected_pixels = {expected_pixels, want};
    else if (produced) expected_pixels = {expected_pixels, res};
    pixels_sent++;
    @(negedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [DATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(int'(idx) * 4);
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_KTOP:   kern[0]    = val[KROW_W-1:0];
      REG_KMID:   kern[1]    = val[KROW_W-1:0];
      REG_KBOT:   kern[2]    = val[KROW_W-1:0];
      REG_WIDTH:  width_reg  = val[WIDTH_W-1:0];
      REG_HEIGHT: height_reg = val[HEIGHT_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    // read back
    psel   <= 1'b1;
    pwrite <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== val) note_mismatch("register read-back", val, prdata);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic configure(input logic [KROW_W-1:0] kt, input logic [KROW_W-1:0] km,
                           input logic [KROW_W-1:0] kb, input logic [WIDTH_W-1:0] w,
                           input logic [HEIGHT_W-1:0] h);
    // drain, then let pixels that make no result clear the pipeline
    push <= 1'b0;
    while (expected_pixels.size() != 0) @(negedge clk_i);
    repeat (12) @(negedge clk_i);
    write_reg(REG_KTOP, DATA_W'(kt));
    write_reg(REG_KMID, DATA_W'(km));
    write_reg(REG_KBOT, DATA_W'(kb));
    write_reg(REG_WIDTH, DATA_W'(w));
    write_reg(REG_HEIGHT, DATA_W'(h));
    settings_run++;
  endtask

  task automatic send_random(input int n);
    pix_in_t item;
    for (int i = 0; i < n; i++) begin
      item.pixel = PIX_W'($urandom_range(0, 255));
      // mostly mark frame starts; rarely restart a frame in the middle
      if (col_cnt == 0 && row_cnt == 0) item.frame_start = ($urandom_range(0, 3) != 0);
      else item.frame_start = ($urandom_range(0, 79) == 0);
      send_pixel(item, 1'b0, '0);
    end
  endtask

  initial begin
    logic [KROW_W-1:0]   k [3];
    logic [WIDTH_W-1:0]  w;
    logic [HEIGHT_W-1:0] h;
    int                  weff, heff, n, ph, guard;
    for (int i = 0; i < MAX_WIDTH; i++) begin
      prev_row[i]  = '0;
      older_row[i] = '0;
    end
    for (int i = 0; i < 9; i++) win[i] = '0;
    kern[0]    = KTOP_RST;
    kern[1]    = KMID_RST;
    kern[2]    = KBOT_RST;
    width_reg  = WIDTH_RST;
    height_reg = HEIGHT_RST;
    col_cnt    = 0;
    row_cnt    = 0;

    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    // hold off while the line store is swept
    while (full) @(negedge clk_i);

    configure(KTOP_RST, KMID_RST, KBOT_RST, 11'd3, 16'd3);
    for (int i = 0; i < DIR_ROWS; i++)
      send_pixel(BLUR_ROWS[i].item, BLUR_ROWS[i].typed, BLUR_ROWS[i].want);

    ph = 0;
    while (pixels_sent < DIR_ROWS + RANDOM_PIXELS) begin
      for (int i = 0; i < 3; i++) begin
        case ($urandom_range(0, 5))
          0:       k[i] = '0;
          1:       k[i] = '1;
          2:       k[i] = KMID_RST;
          default: k[i] = KROW_W'($urandom);
        endcase
        if (ph == 0) k[i] = '1;
        if (ph == 1) k[i] = '0;
      end
      if ($urandom_range(0, 9) == 0) w = WIDTH_W'($urandom_range(0, 2));
      else w = WIDTH_W'($urandom_range(3, 12));
      case ($urandom_range(0, 9))
        0:       h = HEIGHT_W'($urandom_range(0, 2));
        1:       h = '1;
        default: h = HEIGHT_W'($urandom_range(3, 8));
      endcase
      weff = (w < 3) ? 3 : w;
      heff = (h < 3) ? 3 : ((h > 8) ? 6 : h);
      n = weff * heff * $urandom_range(1, 3) + $urandom_range(0, weff);
      configure(k[0], k[1], k[2], w, h);
      send_random(n);
      ph++;
    end

    push <= 1'b0;
    guard = 0;
    while (expected_pixels.size() != 0 && guard < 200000) begin
      @(posedge clk_i);
      guard++;
    end
    if (expected_pixels.size() != 0)
      note_mismatch("results never delivered", expected_pixels.size(), 0);
    repeat (20) @(posedge clk_i);

    $display("Covered %0d pixels over %0d register settings, %0d filtered beats checked.",
             pixels_sent, settings_run, results_checked);
    $display("Mismatches: %0d", mismatches);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
